@@ rtl/bpa_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpa_pkg
// Shared constants, types and codes of the bitmap page allocator.
// ----------------------------------------------------------------------------
package bpa_pkg;

  localparam int PAGE_COUNT     = 32768;
  localparam int PAGE_SHIFT     = 12;
  localparam int RESERVED_PAGES = 512;

  localparam int WORD_W      = 64;
  localparam int BIT_IDX_W   = $clog2(WORD_W);
  localparam int MAP_WORDS   = (PAGE_COUNT + WORD_W - 1) / WORD_W;
  localparam int WORD_IDX_W  = $clog2(MAP_WORDS);
  localparam int HINT_W      = WORD_IDX_W + 1;
  localparam int PAGE_IDX_W  = WORD_IDX_W + BIT_IDX_W;

  localparam int ADDR_IN_W   = 52;
  localparam int IN_DATA_W   = 56;
  localparam int PAGE_ADDR_W = 27;
  localparam int OUT_DATA_W  = 32;
  localparam int STATUS_W    = 2;
  localparam int PFN_W       = ADDR_IN_W - PAGE_SHIFT;

  localparam int RES_PAGES      = (RESERVED_PAGES > PAGE_COUNT) ? PAGE_COUNT : RESERVED_PAGES;
  localparam int RES_FULL_WORDS = RES_PAGES / WORD_W;
  localparam int RES_REM_BITS   = RES_PAGES % WORD_W;
  localparam logic [WORD_W-1:0] RES_PART_WORD = (WORD_W'(1) << RES_REM_BITS) - WORD_W'(1);

  localparam logic [STATUS_W-1:0] STATUS_OK         = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_OOM        = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_MISALIGNED = 2'd2;
  localparam logic [STATUS_W-1:0] STATUS_RANGE      = 2'd3;

  localparam logic ACTION_ALLOC = 1'b0;
  localparam logic ACTION_FREE  = 1'b1;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ALLOC_RD,
    ST_ALLOC_CHK,
    ST_FREE_CHK,
    ST_FREE_WR,
    ST_RESP
  } state_t;

  typedef struct packed {
    logic clear_wr;
    logic latch_req;
    logic alloc_rd;
    logic alloc_wr;
    logic hint_inc;
    logic set_oom;
    logic set_misalign;
    logic set_range;
    logic free_rd;
    logic free_wr;
  } ctl_cmd_t;

  typedef struct packed {
    logic clear_last;
    logic hint_end;
    logic word_full;
    logic misaligned;
    logic out_of_range;
  } dp_stat_t;

endpackage

@@ rtl/bitmap_page_allocator.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bitmap_page_allocator
// Physical page frame allocator over a one-bit-per-page bitmap.
// ----------------------------------------------------------------------------
// Requests come in on the s_ channel, one transfer per request: tuser is the
// action (0 allocate, 1 free), tdata the byte address of the page to free.
// Each request gives exactly one result transfer on the m_ channel: tdata
// is the allocated page address (zero for a free or an error), tuser the
// status code. The block works on one request at a time. An allocate reads
// the bitmap word at the hint and checks it, moving on to the next word
// while the word read is full, then writes the word back with its lowest
// free bit set; with the hint past the last word it gives out of memory
// without a read. A free checks alignment and range, then reads the word
// and writes it back with the page's bit cleared. The scan starts at a
// hint, the lowest word that may hold a free page, so it only passes full
// words after a low page that was freed is granted again.
// The bitmap is a 512 x 64 single-port-style memory, one word read or
// written per cycle. After reset a clearing pass writes all 512 words of
// the initial bitmap (reserved pages marked used) with s_tready held low.
// A result waits in its register until m_tready is high; no new request is
// accepted until it has been taken.
// ----------------------------------------------------------------------------
module bitmap_page_allocator (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  input  logic [bpa_pkg::IN_DATA_W-1:0]      s_tdata,   // [51:0] address
  input  logic [0:0]                         s_tuser,   // [0] action
  output logic                               m_tvalid,
  input  logic                               m_tready,
  output logic [bpa_pkg::OUT_DATA_W-1:0]     m_tdata,   // [26:0] page_address
  output logic [bpa_pkg::STATUS_W-1:0]       m_tuser    // [1:0] status
);
  import bpa_pkg::*;

  ctl_cmd_t                cmd;
  dp_stat_t                stat;
  logic [PAGE_ADDR_W-1:0]  page_address;

  bpa_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .action   (s_tuser[0]),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  bpa_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .req_address  (s_tdata[ADDR_IN_W-1:0]),
    .page_address (page_address),
    .status       (m_tuser)
  );

  assign m_tdata = OUT_DATA_W'(page_address);

endmodule

@@ rtl/bpa_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpa_ctrl
// Sequencer of the allocator: clearing pass, request decode, bitmap scan and
// read-modify-write steps, result handoff.
// ----------------------------------------------------------------------------
module bpa_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic              action,
  output logic              m_tvalid,
  input  logic              m_tready,
  input  bpa_pkg::dp_stat_t stat,
  output bpa_pkg::ctl_cmd_t cmd
);
  import bpa_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: begin
        if (stat.clear_last) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (s_tvalid) state_next = (action == ACTION_FREE) ? ST_FREE_CHK : ST_ALLOC_RD;
      end
      ST_ALLOC_RD: begin
        state_next = stat.hint_end ? ST_RESP : ST_ALLOC_CHK;
      end
      ST_ALLOC_CHK: begin
        state_next = stat.word_full ? ST_ALLOC_RD : ST_RESP;
      end
      ST_FREE_CHK: begin
        state_next = (stat.misaligned || stat.out_of_range) ? ST_RESP : ST_FREE_WR;
      end
      ST_FREE_WR: begin
        state_next = ST_RESP;
      end
      ST_RESP: begin
        if (m_tready) state_next = ST_IDLE;
      end
      default: state_next = ST_CLEAR;
    endcase
  end

  always_comb begin
    cmd      = '0;
    s_tready = 1'b0;
    m_tvalid = 1'b0;
    unique case (state)
      ST_CLEAR: begin
        cmd.clear_wr = 1'b1;
      end
      ST_IDLE: begin
        s_tready      = 1'b1;
        cmd.latch_req = s_tvalid;
      end
      ST_ALLOC_RD: begin
        cmd.set_oom  = stat.hint_end;
        cmd.alloc_rd = !stat.hint_end;
      end
      ST_ALLOC_CHK: begin
        cmd.hint_inc = stat.word_full;
        cmd.alloc_wr = !stat.word_full;
      end
      ST_FREE_CHK: begin
        priority if (stat.misaligned) begin
          cmd.set_misalign = 1'b1;
        end else if (stat.out_of_range) begin
          cmd.set_range = 1'b1;
        end else begin
          cmd.free_rd = 1'b1;
        end
      end
      ST_FREE_WR: begin
        cmd.free_wr = 1'b1;
      end
      ST_RESP: begin
        m_tvalid = 1'b1;
      end
      default: ;
    endcase
  end

endmodule

@@ rtl/bpa_datapath.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpa_datapath
// Bitmap memory, lowest-free-word hint, request and result registers.
// ----------------------------------------------------------------------------
module bpa_datapath (
  input  logic                                 clk,
  input  logic                                 rst,
  input  bpa_pkg::ctl_cmd_t                    cmd,
  output bpa_pkg::dp_stat_t                    stat,
  input  logic [bpa_pkg::ADDR_IN_W-1:0]        req_address,
  output logic [bpa_pkg::PAGE_ADDR_W-1:0]      page_address,
  output logic [bpa_pkg::STATUS_W-1:0]         status
);
  import bpa_pkg::*;

  logic [WORD_W-1:0]     mem [MAP_WORDS];
  logic [WORD_W-1:0]     rd_data;
  logic                  rd_en;
  logic [WORD_IDX_W-1:0] rd_addr;
  logic                  wr_en;
  logic [WORD_IDX_W-1:0] wr_addr;
  logic [WORD_W-1:0]     wr_data;

  logic [HINT_W-1:0]     clr_cnt;
  logic [HINT_W-1:0]     hint;
  logic [ADDR_IN_W-1:0]  addr_reg;

  logic [PFN_W-1:0]      pfn;
  logic [WORD_IDX_W-1:0] free_word;
  logic [BIT_IDX_W-1:0]  free_bit;
  logic [BIT_IDX_W-1:0]  zero_bit;
  logic [WORD_W-1:0]     alloc_word;
  logic [WORD_W-1:0]     clr_word;
  logic [PAGE_IDX_W-1:0] alloc_page;

  function automatic logic [BIT_IDX_W-1:0] lowest_zero(input logic [WORD_W-1:0] w);
    logic [BIT_IDX_W-1:0] n;
    n = '0;
    for (int i = WORD_W - 1; i >= 0; i--) begin
      if (!w[i]) n = BIT_IDX_W'(i);
    end
    return n;
  endfunction

  assign pfn        = addr_reg[ADDR_IN_W-1:PAGE_SHIFT];
  assign free_word  = pfn[PAGE_IDX_W-1:BIT_IDX_W];
  assign free_bit   = pfn[BIT_IDX_W-1:0];
  assign zero_bit   = lowest_zero(rd_data);
  assign alloc_word = rd_data | (WORD_W'(1) << zero_bit);
  assign alloc_page = {hint[WORD_IDX_W-1:0], zero_bit};

  always_comb begin
    if (clr_cnt < HINT_W'(RES_FULL_WORDS)) begin
      clr_word = '1;
    end else if (clr_cnt == HINT_W'(RES_FULL_WORDS)) begin
      clr_word = RES_PART_WORD;
    end else begin
      clr_word = '0;
    end
  end

  assign stat.clear_last   = (clr_cnt == HINT_W'(MAP_WORDS - 1));
  assign stat.hint_end     = (hint == HINT_W'(MAP_WORDS));
  assign stat.word_full    = &rd_data;
  assign stat.misaligned   = |addr_reg[PAGE_SHIFT-1:0];
  assign stat.out_of_range = (pfn >= PFN_W'(PAGE_COUNT));

  assign rd_en   = cmd.alloc_rd | cmd.free_rd;
  assign rd_addr = cmd.free_rd ? free_word : hint[WORD_IDX_W-1:0];
  assign wr_en   = cmd.clear_wr | cmd.alloc_wr | cmd.free_wr;

  always_comb begin
    priority if (cmd.clear_wr) begin
      wr_addr = clr_cnt[WORD_IDX_W-1:0];
      wr_data = clr_word;
    end else if (cmd.free_wr) begin
      wr_addr = free_word;
      wr_data = rd_data & ~(WORD_W'(1) << free_bit);
    end else begin
      wr_addr = hint[WORD_IDX_W-1:0];
      wr_data = alloc_word;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
      hint    <= HINT_W'(RES_FULL_WORDS);
    end else begin
      if (cmd.clear_wr) clr_cnt <= clr_cnt + HINT_W'(1);
      if (cmd.hint_inc || (cmd.alloc_wr && (&alloc_word))) begin
        hint <= hint + HINT_W'(1);
      end else if (cmd.free_wr && ({1'b0, free_word} < hint)) begin
        hint <= {1'b0, free_word};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch_req) addr_reg <= req_address;
    if (cmd.set_oom) begin
      page_address <= '0;
      status       <= STATUS_OOM;
    end else if (cmd.set_misalign) begin
      page_address <= '0;
      status       <= STATUS_MISALIGNED;
    end else if (cmd.set_range) begin
      page_address <= '0;
      status       <= STATUS_RANGE;
    end else if (cmd.free_wr) begin
      page_address <= '0;
      status       <= STATUS_OK;
    end else if (cmd.alloc_wr) begin
      page_address <= PAGE_ADDR_W'({alloc_page, {PAGE_SHIFT{1'b0}}});
      status       <= STATUS_OK;
    end
  end

endmodule

@@ rtl/bpa_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpa_checker
// Port-level checks of the page allocator, bound to the top level.
// ----------------------------------------------------------------------------
module bpa_checker (
  input logic                               clk,
  input logic                               rst,
  input logic                               s_tvalid,
  input logic                               s_tready,
  input logic                               m_tvalid,
  input logic                               m_tready,
  input logic [bpa_pkg::OUT_DATA_W-1:0]     m_tdata,
  input logic [bpa_pkg::STATUS_W-1:0]       m_tuser
);
  import bpa_pkg::*;

  a_reset_busy: assert property (@(posedge clk) rst |=> !s_tready)
    else $error("request accepted right after reset");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("second request accepted while one is in flight");

  a_result_blocks_input: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !s_tready)
    else $error("request accepted while a result is pending");

  a_fail_zero_addr: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (m_tuser != STATUS_OK)) |-> (m_tdata == '0))
    else $error("nonzero page address with error status");

  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
    else $error("stalled result changed");

endmodule

bind bitmap_page_allocator bpa_checker u_bpa_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);
